### rtl/core/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared widths, codes and stage payload types of the particle contact
// generator pipeline.
// ----------------------------------------------------------------------------
package pcg_pkg;

  // coordinate format, signed Q12.12
  localparam int COORD_WIDTH = 24;
  localparam int SIZE_W      = 24;
  localparam int BOUNCE_W    = 16;
  localparam int TAG_W       = 16;
  localparam int NORM_W      = 16;
  localparam int DEPTH_W     = 25;
  localparam int KIND_W      = 2;
  localparam int OP_W        = 2;

  // derived datapath widths
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int ROOT_W = MAG_W + 1;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int FRAC_W = 14;
  localparam int Q_W    = FRAC_W + 1;
  localparam int NUM_W  = ROOT_W + Q_W;
  localparam int CMP_W  = (ROOT_W > DEPTH_W) ? ROOT_W + 1 : DEPTH_W + 1;

  localparam logic [NORM_W-1:0]   NORMAL_ONE = NORM_W'(16384);
  localparam logic [BOUNCE_W-1:0] BOUNCE_ONE = BOUNCE_W'(32768);
  localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = {DEPTH_W{1'b1}};

  // operation codes
  localparam logic [OP_W-1:0] OP_SPHERE = 2'd0;
  localparam logic [OP_W-1:0] OP_ROD    = 2'd1;
  localparam logic [OP_W-1:0] OP_CABLE  = 2'd2;

  // contact kinds
  localparam logic [KIND_W-1:0] KIND_CABLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ROD   = 2'd3;

  // request fields carried along with the geometry
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   radius;
    logic [BOUNCE_W-1:0] bounce;
    logic                kind;
    logic [TAG_W-1:0]    tag;
  } req_t;

  // request plus per-axis difference sign and magnitude
  typedef struct packed {
    req_t                       req;
    logic [2:0]                 neg;
    logic [2:0][MAG_W-1:0]      mag;
  } side_t;

  // contact decision carried through the divider
  typedef struct packed {
    logic                emit;
    logic                zero;
    logic [2:0]          negate;
    logic [DEPTH_W-1:0]  depth;
    logic [BOUNCE_W-1:0] bounce;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tag;
  } res_t;

endpackage

### rtl/core/pcg_if.sv
// ----------------------------------------------------------------------------
// pcg_in_if / pcg_out_if
// Valid/ready channels for contact requests and generated contacts.
// ----------------------------------------------------------------------------
interface pcg_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [pcg_pkg::OP_W-1:0]                  operation;
  logic signed [pcg_pkg::COORD_WIDTH-1:0]    pos_a_x;
  logic signed [pcg_pkg::COORD_WIDTH-1:0]    pos_a_y;
  logic signed [pcg_pkg::COORD_WIDTH-1:0]    pos_a_z;
  logic signed [pcg_pkg::COORD_WIDTH-1:0]    pos_b_x;
  logic signed [pcg_pkg::COORD_WIDTH-1:0]    pos_b_y;
  logic signed [pcg_pkg::COORD_WIDTH-1:0]    pos_b_z;
  logic [pcg_pkg::SIZE_W-1:0]                size_a;
  logic [pcg_pkg::SIZE_W-1:0]                radius_b;
  logic [pcg_pkg::BOUNCE_W-1:0]              bounce;
  logic                                      sphere_kind;
  logic [pcg_pkg::TAG_W-1:0]                 pair_tag;

  modport source (output valid, operation, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y,
                  pos_b_z, size_a, radius_b, bounce, sphere_kind, pair_tag,
                  input ready);
  modport sink   (input valid, operation, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y,
                  pos_b_z, size_a, radius_b, bounce, sphere_kind, pair_tag,
                  output ready);
endinterface

interface pcg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pcg_pkg::NORM_W-1:0]   normal_x;
  logic signed [pcg_pkg::NORM_W-1:0]   normal_y;
  logic signed [pcg_pkg::NORM_W-1:0]   normal_z;
  logic [pcg_pkg::DEPTH_W-1:0]         depth;
  logic [pcg_pkg::BOUNCE_W-1:0]        bounce_out;
  logic [pcg_pkg::KIND_W-1:0]          kind_out;
  logic [pcg_pkg::TAG_W-1:0]           tag_out;

  modport source (output valid, normal_x, normal_y, normal_z, depth, bounce_out, kind_out,
                  tag_out, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, depth, bounce_out, kind_out,
                  tag_out, output ready);
endinterface

### rtl/core/particle_contact_generator.sv
// ----------------------------------------------------------------------------
// particle_contact_generator
// Sphere, rod and cable contact generation for one particle pair per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction: operation, both positions
//   (signed Q12.12), size_a, radius_b, bounce, sphere_kind and pair_tag.
//   out_ch carries at most one contact per request: Q1.14 normal, Q13.12
//   depth, restitution, kind and the echoed pair tag. Requests that make
//   no contact (separated spheres, slack cables, exact rods, operation 3)
//   produce no output transaction; order of contacts follows requests.
// Throughput: one request per cycle while no contact is stalled at the output.
// Pipeline: from acceptance to output valid a request passes through
//   3 front-end stages (difference, square, sum), one square-root stage per
//   distance bit (26), one decision stage, one divider stage per normal
//   quotient bit (15) and the output register.
// Reset: clears every stage valid bit; in_ch.ready rises right away.
// Stall: the whole pipeline holds while a contact waits in the output
//   register; in_ch.ready is low exactly then, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module particle_contact_generator (
  input  logic         clk,
  input  logic         rst,
  pcg_in_if.sink       in_ch,
  pcg_out_if.source    out_ch
);
  import pcg_pkg::*;

  logic                       en;
  req_t                       req_in;
  logic                       fr_valid;
  side_t                      fr_side;
  logic [SUM_W-1:0]           fr_sum;
  logic                       sq_valid;
  logic [ROOT_W-1:0]          sq_root;
  side_t                      sq_side;
  logic                       dc_valid;
  logic [ROOT_W-1:0]          dc_dist;
  logic [2:0][MAG_W-1:0]      dc_mag;
  res_t                       dc_res;
  res_t                       res_c;
  logic                       dv_valid;
  logic [2:0][Q_W-1:0]        dv_quot;
  res_t                       dv_res;
  logic [2:0][NORM_W-1:0]     norm_c;

  // pipeline advances unless a contact is stuck at the output
  assign en           = !out_ch.valid || out_ch.ready;
  assign in_ch.ready  = en;

  assign req_in.op     = in_ch.operation;
  assign req_in.size   = in_ch.size_a;
  assign req_in.radius = in_ch.radius_b;
  assign req_in.bounce = in_ch.bounce;
  assign req_in.kind   = in_ch.sphere_kind;
  assign req_in.tag    = in_ch.pair_tag;

  pcg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_ch.valid),
    .pos_a     ({in_ch.pos_a_z, in_ch.pos_a_y, in_ch.pos_a_x}),
    .pos_b     ({in_ch.pos_b_z, in_ch.pos_b_y, in_ch.pos_b_x}),
    .req_in    (req_in),
    .out_valid (fr_valid),
    .side_out  (fr_side),
    .sum_out   (fr_sum)
  );

  pcg_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .radicand  (fr_sum),
    .side_in   (fr_side),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .side_out  (sq_side)
  );

  // contact decision per operation
  always_comb begin
    logic [CMP_W-1:0]    dist_e;
    logic [CMP_W-1:0]    size_e;
    logic [CMP_W-1:0]    reach;
    logic [CMP_W-1:0]    dep;
    logic [BOUNCE_W-1:0] bsat;
    logic                flip;

    dist_e = CMP_W'(sq_root);
    size_e = CMP_W'(sq_side.req.size);
    reach  = size_e + CMP_W'(sq_side.req.radius);
    bsat   = (sq_side.req.bounce > BOUNCE_ONE) ? BOUNCE_ONE : sq_side.req.bounce;
    dep    = '0;
    flip   = 1'b0;
    res_c.emit   = 1'b0;
    res_c.bounce = bsat;
    res_c.kind   = {1'b0, sq_side.req.kind};
    unique case (sq_side.req.op)
      OP_SPHERE: begin
        res_c.emit = reach > dist_e;
        dep        = reach - dist_e;
        flip       = 1'b1;
      end
      OP_ROD: begin
        res_c.emit   = dist_e != size_e;
        flip         = !(dist_e > size_e);
        dep          = flip ? size_e - dist_e : dist_e - size_e;
        res_c.bounce = '0;
        res_c.kind   = KIND_ROD;
      end
      OP_CABLE: begin
        res_c.emit = dist_e >= size_e;
        dep        = dist_e - size_e;
        res_c.kind = KIND_CABLE;
      end
      default: begin
        res_c.emit = 1'b0;
      end
    endcase
    res_c.depth  = (dep > CMP_W'(DEPTH_MAX)) ? DEPTH_MAX : dep[DEPTH_W-1:0];
    res_c.zero   = sq_root == '0;
    res_c.negate = sq_side.neg ^ {3{flip}};
    res_c.tag    = sq_side.req.tag;
  end

  // decision register
  always_ff @(posedge clk) begin
    if (rst) begin
      dc_valid <= 1'b0;
    end else if (en) begin
      dc_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dc_dist <= sq_root;
      dc_mag  <= sq_side.mag;
      dc_res  <= res_c;
    end
  end

  pcg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dc_valid),
    .denom     (dc_dist),
    .mag       (dc_mag),
    .res_in    (dc_res),
    .out_valid (dv_valid),
    .quot      (dv_quot),
    .res_out   (dv_res)
  );

  // cap, sign and zero-distance handling of the normal
  always_comb begin
    logic [NORM_W-1:0] mag_n;
    for (int i = 0; i < 3; i++) begin
      mag_n     = (NORM_W'(dv_quot[i]) > NORMAL_ONE) ? NORMAL_ONE : NORM_W'(dv_quot[i]);
      norm_c[i] = dv_res.zero ? '0 : (dv_res.negate[i] ? -mag_n : mag_n);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= dv_valid && dv_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.normal_x   <= norm_c[0];
      out_ch.normal_y   <= norm_c[1];
      out_ch.normal_z   <= norm_c[2];
      out_ch.depth      <= dv_res.depth;
      out_ch.bounce_out <= dv_res.bounce;
      out_ch.kind_out   <= dv_res.kind;
      out_ch.tag_out    <= dv_res.tag;
    end
  end

endmodule

### rtl/core/pcg_front.sv
// ----------------------------------------------------------------------------
// pcg_front
// Three stage front end: coordinate differences, squared magnitudes and
// their sum.
// ----------------------------------------------------------------------------
module pcg_front (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [2:0][pcg_pkg::COORD_WIDTH-1:0]         pos_a,
  input  logic [2:0][pcg_pkg::COORD_WIDTH-1:0]         pos_b,
  input  pcg_pkg::req_t                                req_in,
  output logic                                         out_valid,
  output pcg_pkg::side_t                               side_out,
  output logic [pcg_pkg::SUM_W-1:0]                    sum_out
);
  import pcg_pkg::*;

  localparam int SQ_W = 2 * MAG_W;

  logic                       v1, v2;
  logic [2:0][MAG_W-1:0]      diff1;
  req_t                       req1;
  side_t                      side2;
  logic [2:0][SQ_W-1:0]       sq2;
  logic [2:0]                 neg_c;
  logic [2:0][MAG_W-1:0]      mag_c;
  logic [2:0][SQ_W-1:0]       sq_c;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // stage 1: b minus a per axis
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        diff1[i] <= {pos_b[i][COORD_WIDTH-1], pos_b[i]} - {pos_a[i][COORD_WIDTH-1], pos_a[i]};
      end
      req1 <= req_in;
    end
  end

  // magnitude and square per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = diff1[i][MAG_W-1];
      mag_c[i] = neg_c[i] ? -diff1[i] : diff1[i];
      sq_c[i]  = SQ_W'(mag_c[i]) * SQ_W'(mag_c[i]);
    end
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    if (en) begin
      sq2            <= sq_c;
      side2.req      <= req1;
      side2.neg      <= neg_c;
      side2.mag      <= mag_c;
    end
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sum_out  <= SUM_W'(sq2[0]) + SUM_W'(sq2[1]) + SUM_W'(sq2[2]);
      side_out <= side2;
    end
  end

endmodule

### rtl/core/pcg_sqrt.sv
// ----------------------------------------------------------------------------
// pcg_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pcg_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [pcg_pkg::SUM_W-1:0]    radicand,
  input  pcg_pkg::side_t               side_in,
  output logic                         out_valid,
  output logic [pcg_pkg::ROOT_W-1:0]   root_out,
  output pcg_pkg::side_t               side_out
);
  import pcg_pkg::*;

  logic                v   [ROOT_W+1];
  logic [REM_W-1:0]    rem [ROOT_W+1];
  logic [ROOT_W-1:0]   root[ROOT_W+1];
  logic [SUM_W-1:0]    rad [ROOT_W+1];
  side_t               side[ROOT_W+1];

  assign v[0]    = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = radicand;
  assign side[0] = side_in;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int K = ROOT_W - 1 - i;
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             take;

    // bring down the next two radicand bits and try a one
    assign shifted = {rem[i][REM_W-3:0], rad[i][2*K+1:2*K]};
    assign trial   = REM_W'({root[i], 2'b01});
    assign take    = shifted >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? shifted - trial : shifted;
        root[i+1] <= {root[i][ROOT_W-2:0], take};
        rad[i+1]  <= rad[i];
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign root_out  = root[ROOT_W];
  assign side_out  = side[ROOT_W];

endmodule

### rtl/core/pcg_div.sv
// ----------------------------------------------------------------------------
// pcg_div
// Three lane pipelined restoring divider for the rounded unit normal,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module pcg_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [pcg_pkg::ROOT_W-1:0]           denom,
  input  logic [2:0][pcg_pkg::MAG_W-1:0]       mag,
  input  pcg_pkg::res_t                        res_in,
  output logic                                 out_valid,
  output logic [2:0][pcg_pkg::Q_W-1:0]         quot,
  output pcg_pkg::res_t                        res_out
);
  import pcg_pkg::*;

  logic                       v  [Q_W+1];
  logic [ROOT_W-1:0]          dv [Q_W+1];
  logic [2:0][NUM_W-1:0]      r  [Q_W+1];
  logic [2:0][Q_W-1:0]        q  [Q_W+1];
  res_t                       rs [Q_W+1];

  // numerator: magnitude scaled to Q1.14 plus half the divisor for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[0][i] = (NUM_W'(mag[i]) << FRAC_W) + NUM_W'(denom >> 1);
    end
  end

  assign v[0]  = in_valid;
  assign dv[0] = denom;
  assign q[0]  = '0;
  assign rs[0] = res_in;

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int K = Q_W - 1 - s;
    logic [NUM_W-1:0]     dsh;
    logic [2:0][NUM_W-1:0] r_next;
    logic [2:0][Q_W-1:0]   q_next;

    assign dsh = NUM_W'(dv[s]) << K;

    // subtract the shifted divisor where it fits
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r_next[i] = r[s][i];
        q_next[i] = q[s][i];
        if (r[s][i] >= dsh) begin
          r_next[i]    = r[s][i] - dsh;
          q_next[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (en) begin
        v[s+1] <= v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[s+1]  <= r_next;
        q[s+1]  <= q_next;
        dv[s+1] <= dv[s];
        rs[s+1] <= rs[s];
      end
    end
  end

  assign out_valid = v[Q_W];
  assign quot      = q[Q_W];
  assign res_out   = rs[Q_W];

endmodule

### rtl/core/pcg_chk.sv
// ----------------------------------------------------------------------------
// pcg_chk
// Port-level checks of the contact generator, bound to the top level.
// ----------------------------------------------------------------------------
module pcg_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pcg_pkg::NORM_W-1:0]         normal_x,
  input logic [pcg_pkg::BOUNCE_W-1:0]       bounce_out,
  input logic [pcg_pkg::KIND_W-1:0]         kind_out
);
  import pcg_pkg::*;

  // a held contact stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("contact dropped while stalled");

  // a stalled output blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted during output stall");

  // rods carry no restitution
  a_rod_bounce: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind_out == KIND_ROD |-> bounce_out == '0)
    else $error("rod contact with nonzero restitution");

  // normal x component and restitution stay within one
  a_ranges: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bounce_out <= BOUNCE_ONE &&
      ($signed(normal_x) <= $signed(NORMAL_ONE)) && ($signed(normal_x) >= -$signed(NORMAL_ONE)))
    else $error("normal or restitution out of range");

endmodule

bind particle_contact_generator pcg_chk u_pcg_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .normal_x   (out_ch.normal_x),
  .bounce_out (out_ch.bounce_out),
  .kind_out   (out_ch.kind_out)
);
